>>> rtl/core/lfsa_pkg.sv
// Shared types and constants for the lowest-free slot allocator.
// No dependencies; imported by the scan unit, the bitmap store and the top level.
package lfsa_pkg;

  localparam int unsigned WordBits  = 32;
  localparam int unsigned WordShift = 5;
  localparam int unsigned CapW      = 9;
  localparam int unsigned CapReset  = 256;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_FULL         = 2'd1,
    ST_RANGE        = 2'd2,
    ST_ALREADY_FREE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FREE
  } state_e;

  // Result of one word search.
  typedef struct packed {
    logic                 found;
    logic [WordShift-1:0] bit_pos;
  } hit_t;

endpackage

>>> rtl/core/lowest_free_slot_allocator.sv
// Lowest-free-first slot allocator: sequencer over a word bitmap and a shared scan unit.
// Free reads the slot's word and clears its bit. Allocate reads the hint word and steps word
// by word to find the grant, marks it, then keeps stepping to find the next hint. Out-of-range free
// and allocate with hint at the end answer straight from idle with no bitmap read. One request at a time.
// Reset: all slots free (word valid flops clear at once), hint and count zero, capacity 256.
// Depends on lfsa_pkg, lfsa_ffz, lfsa_bitmap.
module lowest_free_slot_allocator #(
  parameter int unsigned TABLE_SLOTS = 256
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [lfsa_pkg::CapW-1:0] cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     operation_i,
  input  logic [7:0]               slot_index_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [7:0]               granted_slot_o,
  output logic [1:0]               status_o,
  output logic [8:0]               in_use_count_o
);
  import lfsa_pkg::*;

  localparam int unsigned SzRaw  = $clog2(TABLE_SLOTS + 1);
  localparam int unsigned SzW    = (SzRaw > CapW) ? SzRaw : CapW;
  localparam int unsigned CntW   = SzRaw;
  localparam int unsigned Words  = (TABLE_SLOTS + WordBits - 1) / WordBits;
  localparam int unsigned WordAw = (Words > 1) ? $clog2(Words) : 1;

  state_e              state_q, state_d;
  logic                phase_q, phase_d;   // 0: find grant, 1: find next hint
  logic [WordAw-1:0]   word_q, word_d;
  logic [SzW-1:0]      from_q, from_d;
  logic [SzW-1:0]      grant_q, grant_d;
  logic [SzW-1:0]      idx_q, idx_d;
  logic [SzW-1:0]      hint_q, hint_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [CapW-1:0]     cap_q;
  logic                out_valid_q, out_valid_d;
  logic [7:0]          out_slot_q, out_slot_d;
  status_e             out_status_q, out_status_d;
  logic [8:0]          out_count_q, out_count_d;

  logic [SzW-1:0]      size;
  logic [SzW-1:0]      idx_ext;
  logic [SzW-1:0]      base;
  logic [SzW-1:0]      slot;
  logic [SzW:0]        next_base;
  logic                accept;

  logic                rd_en;
  logic [WordAw-1:0]   rd_addr;
  logic [WordBits-1:0] rd_word;
  logic                wr_en;
  logic [WordAw-1:0]   wr_addr;
  logic [WordBits-1:0] wr_word;
  hit_t                hit;

  assign size = (SzW'(cap_q) > SzW'(TABLE_SLOTS)) ? SzW'(TABLE_SLOTS) : SzW'(cap_q);
  assign idx_ext   = SzW'(slot_index_i);
  assign base      = SzW'({word_q, {WordShift{1'b0}}});
  assign slot      = base + SzW'(hit.bit_pos);
  assign next_base = (SzW+1)'(base) + (SzW+1)'(WordBits);

  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  lfsa_bitmap #(
    .Words (Words),
    .WordAw(WordAw)
  ) u_bitmap (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_word_o(rd_word),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_word_i(wr_word)
  );

  lfsa_ffz #(
    .SzW(SzW)
  ) u_ffz (
    .word_i(rd_word),
    .base_i(base),
    .from_i(from_q),
    .size_i(size),
    .hit_o (hit)
  );

  always_comb begin
    state_d      = state_q;
    phase_d      = phase_q;
    word_d       = word_q;
    from_d       = from_q;
    grant_d      = grant_q;
    idx_d        = idx_q;
    hint_d       = hint_q;
    count_d      = count_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_slot_d   = out_slot_q;
    out_status_d = out_status_q;
    out_count_d  = out_count_q;
    rd_en        = 1'b0;
    rd_addr      = word_q;
    wr_en        = 1'b0;
    wr_addr      = word_q;
    wr_word      = rd_word;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (op_e'(operation_i) == OP_ALLOC) begin
            if (hint_q >= size) begin
              out_valid_d  = 1'b1;
              out_slot_d   = '0;
              out_status_d = ST_FULL;
              out_count_d  = 9'(count_q);
            end else begin
              rd_en   = 1'b1;
              rd_addr = hint_q[WordAw+WordShift-1:WordShift];
              word_d  = hint_q[WordAw+WordShift-1:WordShift];
              from_d  = hint_q;
              phase_d = 1'b0;
              state_d = S_SCAN;
            end
          end else begin
            if (idx_ext >= size) begin
              out_valid_d  = 1'b1;
              out_slot_d   = '0;
              out_status_d = ST_RANGE;
              out_count_d  = 9'(count_q);
            end else begin
              rd_en   = 1'b1;
              rd_addr = idx_ext[WordAw+WordShift-1:WordShift];
              word_d  = idx_ext[WordAw+WordShift-1:WordShift];
              idx_d   = idx_ext;
              state_d = S_FREE;
            end
          end
        end
      end

      S_SCAN: begin
        if (hit.found) begin
          if (!phase_q) begin
            // Mark the grant; the window start skips it on the hint pass.
            wr_en   = 1'b1;
            wr_word = rd_word | (WordBits'(1) << hit.bit_pos);
            grant_d = slot;
            count_d = count_q + CntW'(1);
            from_d  = slot + SzW'(1);
            phase_d = 1'b1;
          end else begin
            hint_d       = slot;
            out_valid_d  = 1'b1;
            out_slot_d   = grant_q[7:0];
            out_status_d = ST_OK;
            out_count_d  = 9'(count_q);
            state_d      = S_IDLE;
          end
        end else if (next_base < (SzW+1)'(size)) begin
          // Advance to the next word.
          rd_en   = 1'b1;
          rd_addr = word_q + WordAw'(1);
          word_d  = word_q + WordAw'(1);
          from_d  = next_base[SzW-1:0];
        end else begin
          out_valid_d = 1'b1;
          out_count_d = 9'(count_q);
          state_d     = S_IDLE;
          if (!phase_q) begin
            out_slot_d   = '0;
            out_status_d = ST_FULL;
          end else begin
            hint_d       = size;
            out_slot_d   = grant_q[7:0];
            out_status_d = ST_OK;
          end
        end
      end

      S_FREE: begin
        out_valid_d = 1'b1;
        out_slot_d  = '0;
        state_d     = S_IDLE;
        if (rd_word[idx_q[WordShift-1:0]]) begin
          wr_en        = 1'b1;
          wr_word      = rd_word & ~(WordBits'(1) << idx_q[WordShift-1:0]);
          out_status_d = ST_OK;
          if (count_q != '0) begin
            count_d = count_q - CntW'(1);
          end
        end else begin
          out_status_d = ST_ALREADY_FREE;
        end
        out_count_d = 9'(count_d);
        if (hint_q > idx_q) begin
          hint_d = idx_q;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= 1'b0;
      hint_q      <= '0;
      count_q     <= '0;
      cap_q       <= CapW'(CapReset);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      hint_q      <= hint_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    word_q       <= word_d;
    from_q       <= from_d;
    grant_q      <= grant_d;
    idx_q        <= idx_d;
    out_slot_q   <= out_slot_d;
    out_status_q <= out_status_d;
    out_count_q  <= out_count_d;
  end

  assign out_valid_o    = out_valid_q;
  assign granted_slot_o = out_slot_q;
  assign status_o       = out_status_q;
  assign in_use_count_o = out_count_q;

endmodule

>>> rtl/core/lfsa_ffz.sv
// Shared scan unit: lowest free bit of one 32-bit bitmap word inside a window.
// Depends on lfsa_pkg.
module lfsa_ffz #(
  parameter int unsigned SzW = 9
) (
  input  logic [lfsa_pkg::WordBits-1:0] word_i,
  input  logic [SzW-1:0]                base_i,
  input  logic [SzW-1:0]                from_i,
  input  logic [SzW-1:0]                size_i,
  output lfsa_pkg::hit_t                hit_o
);
  import lfsa_pkg::*;

  logic [SzW-1:0]     lo_diff;
  logic [SzW-1:0]     hi_diff;
  logic [WordShift:0] lo;
  logic [WordShift:0] hi;

  // Window [lo, hi) inside the word, clamped to the word width.
  always_comb begin
    lo_diff = from_i - base_i;
    hi_diff = size_i - base_i;
    if (from_i <= base_i) begin
      lo = '0;
    end else if (lo_diff >= SzW'(WordBits)) begin
      lo = (WordShift+1)'(WordBits);
    end else begin
      lo = lo_diff[WordShift:0];
    end
    if (size_i <= base_i) begin
      hi = '0;
    end else if (hi_diff >= SzW'(WordBits)) begin
      hi = (WordShift+1)'(WordBits);
    end else begin
      hi = hi_diff[WordShift:0];
    end
  end

  // Priority pick: scan high to low so the lowest free bit wins.
  always_comb begin
    hit_o = '0;
    for (int b = WordBits - 1; b >= 0; b--) begin
      if ((WordShift+1)'(b) >= lo && (WordShift+1)'(b) < hi && !word_i[b]) begin
        hit_o.found   = 1'b1;
        hit_o.bit_pos = WordShift'(b);
      end
    end
  end

endmodule

>>> rtl/core/lfsa_bitmap.sv
// Used-slot bitmap store: 32-bit words, one write and one registered read per cycle.
// Per-word valid flops make unwritten words read as all free. Depends on lfsa_pkg.
module lfsa_bitmap #(
  parameter int unsigned Words  = 8,
  parameter int unsigned WordAw = 3
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rd_en_i,
  input  logic [WordAw-1:0]             rd_addr_i,
  output logic [lfsa_pkg::WordBits-1:0] rd_word_o,
  input  logic                          wr_en_i,
  input  logic [WordAw-1:0]             wr_addr_i,
  input  logic [lfsa_pkg::WordBits-1:0] wr_word_i
);
  import lfsa_pkg::*;

  logic [WordBits-1:0] mem [Words];
  logic [Words-1:0]    valid_q;
  logic [WordBits-1:0] rdata_q;
  logic                rvld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_word_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rvld_q  <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rvld_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_word_o = rvld_q ? rdata_q : '0;

endmodule
